// ===== src/mct_pkg.sv =====
// shared types, token codes and keyword trie tables for the mini C tokenizer
// no dependencies
`default_nettype none

package mct_pkg;

  localparam int PositionBitsDefault = 16;
  localparam int ResultQueueDepth = 4;

  // token kinds
  localparam logic [5:0] KInt      = 6'd0;
  localparam logic [5:0] KQuestion = 6'd5;
  localparam logic [5:0] KColon    = 6'd6;
  localparam logic [5:0] KTilde    = 6'd12;
  localparam logic [5:0] KDec      = 6'd13;
  localparam logic [5:0] KNot      = 6'd14;
  localparam logic [5:0] KMinus    = 6'd15;
  localparam logic [5:0] KPlus     = 6'd16;
  localparam logic [5:0] KStar     = 6'd17;
  localparam logic [5:0] KSlash    = 6'd18;
  localparam logic [5:0] KPercent  = 6'd19;
  localparam logic [5:0] KAnd      = 6'd20;
  localparam logic [5:0] KOr       = 6'd21;
  localparam logic [5:0] KAssign   = 6'd22;
  localparam logic [5:0] KEq       = 6'd23;
  localparam logic [5:0] KNe       = 6'd24;
  localparam logic [5:0] KLt       = 6'd25;
  localparam logic [5:0] KGt       = 6'd26;
  localparam logic [5:0] KLe       = 6'd27;
  localparam logic [5:0] KGe       = 6'd28;
  localparam logic [5:0] KIdent    = 6'd29;
  localparam logic [5:0] KConst    = 6'd30;
  localparam logic [5:0] KLparen   = 6'd31;
  localparam logic [5:0] KRparen   = 6'd32;
  localparam logic [5:0] KLbrace   = 6'd33;
  localparam logic [5:0] KRbrace   = 6'd34;
  localparam logic [5:0] KSemi     = 6'd35;
  localparam logic [5:0] KError    = 6'd36;
  localparam logic [5:0] KEnd      = 6'd37;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        run_end;
  } res_item_t;

  // results of one byte, handed from the lexer step to the queue
  typedef struct packed {
    logic [1:0]          count;
    res_item_t [2:0]     item;
  } push_t;

  typedef enum logic [13:0] {
    M_IDLE       = 14'b00000000000001,
    M_WORD       = 14'b00000000000010,
    M_DIGITS     = 14'b00000000000100,
    M_SLASH      = 14'b00000000001000,
    M_MINUS      = 14'b00000000010000,
    M_BANG       = 14'b00000000100000,
    M_EQ         = 14'b00000001000000,
    M_LT         = 14'b00000010000000,
    M_GT         = 14'b00000100000000,
    M_AMP        = 14'b00001000000000,
    M_BAR        = 14'b00010000000000,
    M_LINE       = 14'b00100000000000,
    M_BLOCK      = 14'b01000000000000,
    M_BLOCK_STAR = 14'b10000000000000
  } mode_t;

  // keyword trie
  localparam int TrieSize = 42;
  localparam logic [5:0] TrieDead = 6'd63;
  localparam logic [5:0] NoKw = 6'd63;

  localparam logic [5:0] TRIE_PARENT [TrieSize] = '{
    6'd0,
    6'd0, 6'd1, 6'd2, 6'd1,
    6'd0, 6'd5, 6'd6, 6'd7,
    6'd0, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13,
    6'd0, 6'd15, 6'd16, 6'd17,
    6'd0, 6'd19,
    6'd0, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd0, 6'd26, 6'd27,
    6'd0, 6'd29, 6'd30, 6'd31, 6'd32,
    6'd0, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40
  };

  localparam logic [7:0] TRIE_CH [TrieSize] = '{
    8'h00,
    "i", "n", "t", "f",
    "v", "o", "i", "d",
    "r", "e", "t", "u", "r", "n",
    "e", "l", "s", "e",
    "d", "o",
    "w", "h", "i", "l", "e",
    "f", "o", "r",
    "b", "r", "e", "a", "k",
    "c", "o", "n", "t", "i", "n", "u", "e"
  };

  localparam logic [5:0] TRIE_KIND [TrieSize] = '{
    NoKw,
    NoKw, NoKw, KInt, 6'd3,
    NoKw, NoKw, NoKw, 6'd1,
    NoKw, NoKw, NoKw, NoKw, NoKw, 6'd2,
    NoKw, NoKw, NoKw, 6'd4,
    NoKw, 6'd7,
    NoKw, NoKw, NoKw, NoKw, 6'd8,
    NoKw, NoKw, 6'd9,
    NoKw, NoKw, NoKw, NoKw, 6'd10,
    NoKw, NoKw, NoKw, NoKw, NoKw, NoKw, NoKw, 6'd11
  };

  // one trie step, parallel compare over all edges
  function automatic logic [5:0] trie_next(logic [5:0] node, logic [7:0] c);
    logic [5:0] r;
    r = TrieDead;
    for (int i = 1; i < TrieSize; i++) begin
      if (TRIE_PARENT[i] == node && TRIE_CH[i] == c) r = 6'(i);
    end
    return r;
  endfunction

  function automatic logic [5:0] word_kind(logic [5:0] node);
    logic [5:0] k;
    k = KIdent;
    if (node < 6'(TrieSize)) begin
      if (TRIE_KIND[node] != NoKw) k = TRIE_KIND[node];
    end
    return k;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

endpackage

`default_nettype wire

// ===== src/mct_lexer.sv =====
// lexer step: scan state registers and the one-byte transition logic
// depends on mct_pkg
`default_nettype none

module mct_lexer
  import mct_pkg::*;
#(
  parameter int PositionBits = PositionBitsDefault
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     fire,
  input  wire in_item_t in_item,
  output push_t         push
);

  mode_t                   mode, mode_next;
  logic [PositionBits-1:0] pos, pos_next;
  logic [PositionBits-1:0] pstart, pstart_next;
  logic [5:0]              node, node_next;
  logic                    halted, halted_next;

  logic [PositionBits-1:0] p, nx;
  logic [7:0]              c;
  logic                    absorbed;
  res_item_t [3:0]         cand;
  logic [3:0]              cand_v;
  logic [1:0]              idx;

  function automatic res_item_t mk(logic [5:0] kind, logic [PositionBits-1:0] s,
                                   logic [PositionBits-1:0] e);
    res_item_t r;
    logic [PositionBits-1:0] d;
    logic [31:0] sw, dw;
    d = e - s;
    sw = 32'(s);
    dw = 32'(d);
    r.token_kind = kind;
    r.token_start = sw[15:0];
    r.token_length = (kind >= KError) ? 16'd0 : dw[15:0];
    r.run_end = 1'b0;
    return r;
  endfunction

  // one byte of scanning
  always_comb begin
    c = in_item.text_byte;
    p = pos;
    nx = pos + 1'b1;
    mode_next = mode;
    pstart_next = pstart;
    node_next = node;
    halted_next = halted;
    absorbed = 1'b0;
    cand = '0;
    cand_v = '0;
    if (!halted) begin
      // continue the pending lexeme
      unique case (mode)
        M_LINE: begin
          absorbed = 1'b1;
          if (c == 8'h0A) mode_next = M_IDLE;
        end
        M_BLOCK: begin
          absorbed = 1'b1;
          if (c == "*") mode_next = M_BLOCK_STAR;
        end
        M_BLOCK_STAR: begin
          absorbed = 1'b1;
          if (c == "/") mode_next = M_IDLE;
          else if (c != "*") mode_next = M_BLOCK;
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            node_next = trie_next(node, c);
            absorbed = 1'b1;
          end else begin
            cand[0] = mk(word_kind(node), pstart, p);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_DIGITS: begin
          if (is_digit(c)) begin
            absorbed = 1'b1;
          end else if (is_alpha(c)) begin
            cand[0] = mk(KError, pstart, pstart);
            cand_v[0] = 1'b1;
            halted_next = 1'b1;
            mode_next = M_IDLE;
            absorbed = 1'b1;
          end else begin
            cand[0] = mk(KConst, pstart, p);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_next = M_LINE;
            absorbed = 1'b1;
          end else if (c == "*") begin
            mode_next = M_BLOCK;
            absorbed = 1'b1;
          end else begin
            cand[0] = mk(KSlash, pstart, p);
            cand_v[0] = 1'b1;
            mode_next = M_IDLE;
          end
        end
        M_MINUS: begin
          cand_v[0] = 1'b1;
          mode_next = M_IDLE;
          if (c == "-") begin
            cand[0] = mk(KDec, pstart, nx);
            absorbed = 1'b1;
          end else begin
            cand[0] = mk(KMinus, pstart, p);
          end
        end
        M_BANG, M_EQ, M_LT, M_GT: begin
          cand_v[0] = 1'b1;
          mode_next = M_IDLE;
          if (c == "=") begin
            absorbed = 1'b1;
            cand[0] = mk(mode == M_BANG ? KNe : mode == M_EQ ? KEq :
                         mode == M_LT ? KLe : KGe, pstart, nx);
          end else begin
            cand[0] = mk(mode == M_BANG ? KNot : mode == M_EQ ? KAssign :
                         mode == M_LT ? KLt : KGt, pstart, p);
          end
        end
        M_AMP, M_BAR: begin
          cand_v[0] = 1'b1;
          mode_next = M_IDLE;
          absorbed = 1'b1;
          if (c == (mode == M_AMP ? 8'("&") : 8'("|"))) begin
            cand[0] = mk(mode == M_AMP ? KAnd : KOr, pstart, nx);
          end else begin
            cand[0] = mk(KError, pstart, pstart);
            halted_next = 1'b1;
          end
        end
        M_IDLE: begin
          absorbed = 1'b0;
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase

      // start a new lexeme
      if (!absorbed) begin
        pstart_next = p;
        if (is_space(c)) begin
          mode_next = M_IDLE;
        end else if (is_alpha(c)) begin
          mode_next = M_WORD;
          node_next = trie_next(6'd0, c);
        end else if (is_digit(c)) begin
          mode_next = M_DIGITS;
        end else begin
          mode_next = M_IDLE;
          cand_v[1] = 1'b1;
          unique case (c)
            "/": begin cand_v[1] = 1'b0; mode_next = M_SLASH; end
            "-": begin cand_v[1] = 1'b0; mode_next = M_MINUS; end
            "!": begin cand_v[1] = 1'b0; mode_next = M_BANG; end
            "=": begin cand_v[1] = 1'b0; mode_next = M_EQ; end
            "<": begin cand_v[1] = 1'b0; mode_next = M_LT; end
            ">": begin cand_v[1] = 1'b0; mode_next = M_GT; end
            "&": begin cand_v[1] = 1'b0; mode_next = M_AMP; end
            "|": begin cand_v[1] = 1'b0; mode_next = M_BAR; end
            "?": cand[1] = mk(KQuestion, p, nx);
            ":": cand[1] = mk(KColon, p, nx);
            "~": cand[1] = mk(KTilde, p, nx);
            "+": cand[1] = mk(KPlus, p, nx);
            "*": cand[1] = mk(KStar, p, nx);
            "%": cand[1] = mk(KPercent, p, nx);
            "(": cand[1] = mk(KLparen, p, nx);
            ")": cand[1] = mk(KRparen, p, nx);
            "{": cand[1] = mk(KLbrace, p, nx);
            "}": cand[1] = mk(KRbrace, p, nx);
            ";": cand[1] = mk(KSemi, p, nx);
            default: begin
              cand[1] = mk(KError, p, p);
              halted_next = 1'b1;
            end
          endcase
        end
      end
    end

    pos_next = nx;

    // end of text: flush the pending lexeme, then the end marker
    if (in_item.final_byte) begin
      if (!halted_next) begin
        cand_v[2] = 1'b1;
        unique case (mode_next)
          M_WORD:   cand[2] = mk(word_kind(node_next), pstart_next, nx);
          M_DIGITS: cand[2] = mk(KConst, pstart_next, nx);
          M_SLASH:  cand[2] = mk(KSlash, pstart_next, nx);
          M_MINUS:  cand[2] = mk(KMinus, pstart_next, nx);
          M_BANG:   cand[2] = mk(KNot, pstart_next, nx);
          M_EQ:     cand[2] = mk(KAssign, pstart_next, nx);
          M_LT:     cand[2] = mk(KLt, pstart_next, nx);
          M_GT:     cand[2] = mk(KGt, pstart_next, nx);
          M_AMP, M_BAR: cand[2] = mk(KError, pstart_next, pstart_next);
          default:  cand_v[2] = 1'b0;
        endcase
      end
      cand[3] = mk(KEnd, nx, nx);
      cand_v[3] = 1'b1;
      mode_next = M_IDLE;
      pos_next = '0;
      pstart_next = '0;
      node_next = 6'd0;
      halted_next = 1'b0;
    end
  end

  // pack the results in order and mark the last one
  always_comb begin
    push = '0;
    idx = 2'd0;
    for (int k = 0; k < 4; k++) begin
      if (cand_v[k]) begin
        push.item[idx] = cand[k];
        idx = idx + 2'd1;
      end
    end
    push.count = idx;
    for (int k = 0; k < 3; k++) begin
      if (idx != 2'd0 && 2'(k) == idx - 2'd1) push.item[k].run_end = 1'b1;
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pos <= '0;
      pstart <= '0;
      node <= 6'd0;
      halted <= 1'b0;
    end else if (fire) begin
      mode <= mode_next;
      pos <= pos_next;
      pstart <= pstart_next;
      node <= node_next;
      halted <= halted_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/mct_queue.sv =====
// result queue: takes up to three results a cycle, hands out one per transfer
// depends on mct_pkg
`default_nettype none

module mct_queue
  import mct_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  fire,
  input  wire push_t push,
  output logic       room,
  output logic       valid,
  input  wire logic  stall,
  output res_item_t  data
);

  localparam int AW = $clog2(ResultQueueDepth);

  res_item_t       slots [ResultQueueDepth];
  logic [AW-1:0]   rd_ptr, wr_ptr;
  logic [AW:0]     count;
  logic            pop;
  logic [1:0]      n_push;

  assign n_push = fire ? push.count : 2'd0;
  assign valid = count != '0;
  assign pop = valid && !stall;
  assign data = slots[rd_ptr];
  assign room = count <= (AW+1)'(ResultQueueDepth - 3);

  // storage
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < n_push) slots[wr_ptr + AW'(k)] <= push.item[k];
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (AW+1)'(n_push) - (AW+1)'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== src/mini_c_tokenizer_top.sv =====
// mini C tokenizer top: a byte per cycle in, a token per cycle out, unless stalled
// a token is queued with the byte that decides it and leaves after those ahead
// throughput: one byte per cycle while the queue holds at most one result;
//   a byte with two or three tokens holds input until at most one is queued
// reset: rst synchronous, clears scan state and empties the result queue
// depends on mct_pkg, mct_lexer, mct_queue
`default_nettype none

module mini_c_tokenizer_top
  import mct_pkg::*;
#(
  parameter int PositionBits = PositionBitsDefault
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output res_item_t      out_data
);

  logic  fire;
  logic  room;
  push_t push;

  assign in_stall = !room;
  assign fire = in_valid && room;

  mct_lexer #(.PositionBits(PositionBits)) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .in_item (in_data),
    .push    (push)
  );

  mct_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .fire  (fire),
    .push  (push),
    .room  (room),
    .valid (out_valid),
    .stall (out_stall),
    .data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/mct_checker.sv =====
// port-level checks for the tokenizer, bound to the top level
// depends on mct_pkg and mini_c_tokenizer_top
`default_nettype none

module mct_checker
  import mct_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire res_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // nothing to show right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // the last byte of a text always leaves at least its end marker
  a_final_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && in_data.final_byte |=> out_valid)
    else $error("no result after last byte");

  // the end marker closes the results of its byte
  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.token_kind == KEnd |-> out_data.run_end)
    else $error("end marker not last of its byte");

endmodule

bind mini_c_tokenizer_top mct_checker u_mct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
